// ===== hw/rtl/spg_pkg.sv =====
// spg_pkg: shared types and constants for the sieve prime generator.
// Used by the channel interfaces, the engine, the map memory and the top level.
package spg_pkg;

   localparam int LIM_W = 16;
   localparam int POS_W = 17;
   localparam int MUL_W = 18;
   localparam int EPOCH_W = 4;

   localparam logic [LIM_W-1:0] LIMIT_RESET = 16'hFFFF;
   localparam logic [POS_W-1:0] SCAN_START = 17'd2;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 4'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST = 4'd15;
   localparam logic [EPOCH_W-1:0] EPOCH_NONE = 4'd0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_POST,
      ST_MARK
   } spg_state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } spg_ram_ctl_type;

endpackage

// ===== hw/rtl/spg_if.sv =====
// spg_if: valid/ready channel interfaces for requests and responses.
// Depends on spg_pkg for field widths.
interface spg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface spg_rsp_if;
   logic valid;
   logic ready;
   logic [spg_pkg::LIM_W-1:0] prime;
   logic exhausted;

   modport source (output valid, output prime, output exhausted, input ready);
   modport sink (input valid, input prime, input exhausted, output ready);
endinterface

// ===== hw/rtl/spg_map_ram.sv =====
// spg_map_ram: composite map storage, one write and one registered read port.
// Each entry holds the epoch tag under which it was last marked. Uses spg_pkg.
module spg_map_ram #(
   parameter int MAP_AW = 16,
   parameter int MAP_DEPTH = 65536
) (
   input  logic                          clock,
   input  spg_pkg::spg_ram_ctl_type      ctl,
   input  logic [MAP_AW-1:0]             waddr,
   input  logic [spg_pkg::EPOCH_W-1:0]   wdata,
   input  logic [MAP_AW-1:0]             raddr,
   output logic [spg_pkg::EPOCH_W-1:0]   rdata
);

   logic [spg_pkg::EPOCH_W-1:0] mem [MAP_DEPTH];
   logic [spg_pkg::EPOCH_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/spg_engine.sv =====
// spg_engine: scan, mark and clear sequencer plus the response register.
// Drives spg_map_ram; uses spg_pkg and the spg_req_if / spg_rsp_if channels.
module spg_engine #(
   parameter int LIMIT_MAX = 65535,
   parameter int MAP_AW = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   spg_req_if.sink                       req_chan,
   spg_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [spg_pkg::LIM_W-1:0]     lim,
   output spg_pkg::spg_ram_ctl_type      ram_ctl,
   output logic [MAP_AW-1:0]             ram_waddr,
   output logic [spg_pkg::EPOCH_W-1:0]   ram_wdata,
   output logic [MAP_AW-1:0]             ram_raddr,
   input  logic [spg_pkg::EPOCH_W-1:0]   ram_rdata
);

   spg_pkg::spg_state_type state_ff, state_in;

   logic                          busy_ff, busy_in;
   logic                          pend_ff, pend_in;
   logic [spg_pkg::EPOCH_W-1:0]   epoch_ff, epoch_in;
   logic [spg_pkg::POS_W-1:0]     scan_ff, scan_in;
   logic [spg_pkg::POS_W-1:0]     addr_ff, addr_in;
   logic [spg_pkg::POS_W-1:0]     chk_pos_ff, chk_pos_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic [MAP_AW-1:0]             clr_addr_ff, clr_addr_in;
   logic [spg_pkg::POS_W-1:0]     p_ff, p_in;
   logic [spg_pkg::MUL_W-1:0]     m_ff, m_in;
   logic [spg_pkg::LIM_W-1:0]     res_prime_ff, res_prime_in;
   logic                          res_exh_ff, res_exh_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [spg_pkg::LIM_W-1:0]     rsp_prime_ff, rsp_prime_in;
   logic                          rsp_exh_ff, rsp_exh_in;

   logic                          accept;
   logic                          rst_eff;
   logic                          clr_done;
   logic                          chk_exh;
   logic                          chk_found;
   logic                          post_load;
   logic                          mark_go;
   logic [spg_pkg::POS_W-1:0]     lim_pos;

   assign lim_pos = {1'b0, lim};
   assign accept = req_chan.valid && req_chan.ready;
   assign rst_eff = req_chan.restart || pend_ff;
   assign clr_done = (clr_addr_ff == MAP_AW'(LIMIT_MAX));
   assign chk_exh = chk_vld_ff && (chk_pos_ff > lim_pos);
   assign chk_found = chk_vld_ff && !(chk_pos_ff > lim_pos) && (ram_rdata != epoch_ff);
   assign post_load = (state_ff == spg_pkg::ST_POST) && (!rsp_valid_ff || rsp_chan.ready);
   assign mark_go = (m_ff <= {2'b00, lim});

   assign req_chan.ready = (state_ff == spg_pkg::ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.prime = rsp_prime_ff;
   assign rsp_chan.exhausted = rsp_exh_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spg_pkg::ST_CLEAR: begin
            if (clr_done) begin
               state_in = busy_ff ? spg_pkg::ST_SCAN : spg_pkg::ST_IDLE;
            end
         end
         spg_pkg::ST_IDLE: begin
            if (accept) begin
               if (rst_eff && (epoch_ff == spg_pkg::EPOCH_LAST)) begin
                  state_in = spg_pkg::ST_CLEAR;
               end else begin
                  state_in = spg_pkg::ST_SCAN;
               end
            end
         end
         spg_pkg::ST_SCAN: begin
            if (chk_exh || chk_found) begin
               state_in = spg_pkg::ST_POST;
            end
         end
         spg_pkg::ST_POST: begin
            if (post_load) begin
               state_in = res_exh_ff ? spg_pkg::ST_IDLE : spg_pkg::ST_MARK;
            end
         end
         spg_pkg::ST_MARK: begin
            if (!mark_go) begin
               state_in = spg_pkg::ST_IDLE;
            end
         end
         default: state_in = spg_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      busy_in = busy_ff;
      pend_in = pend_ff;
      epoch_in = epoch_ff;
      scan_in = scan_ff;
      addr_in = addr_ff;
      chk_pos_in = chk_pos_ff;
      chk_vld_in = chk_vld_ff;
      clr_addr_in = clr_addr_ff;
      p_in = p_ff;
      m_in = m_ff;
      res_prime_in = res_prime_ff;
      res_exh_in = res_exh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_prime_in = rsp_prime_ff;
      rsp_exh_in = rsp_exh_ff;
      ram_ctl.wr_en = 1'b0;
      ram_ctl.rd_en = 1'b0;
      ram_waddr = clr_addr_ff;
      ram_wdata = spg_pkg::EPOCH_NONE;
      ram_raddr = MAP_AW'(addr_ff);

      case (state_ff)
         spg_pkg::ST_CLEAR: begin
            ram_ctl.wr_en = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_done) begin
               busy_in = 1'b0;
            end
         end
         spg_pkg::ST_IDLE: begin
            if (accept) begin
               pend_in = 1'b0;
               chk_vld_in = 1'b0;
               addr_in = rst_eff ? spg_pkg::SCAN_START : scan_ff;
               if (rst_eff) begin
                  if (epoch_ff == spg_pkg::EPOCH_LAST) begin
                     epoch_in = spg_pkg::EPOCH_FIRST;
                     busy_in = 1'b1;
                     clr_addr_in = '0;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                  end
               end
            end
         end
         spg_pkg::ST_SCAN: begin
            if (chk_exh) begin
               res_exh_in = 1'b1;
               res_prime_in = '0;
               scan_in = lim_pos + 1'b1;
            end else if (chk_found) begin
               res_exh_in = 1'b0;
               res_prime_in = chk_pos_ff[spg_pkg::LIM_W-1:0];
               p_in = chk_pos_ff;
               m_in = {chk_pos_ff, 1'b0};
               scan_in = chk_pos_ff + 1'b1;
            end else begin
               ram_ctl.rd_en = 1'b1;
               addr_in = addr_ff + 1'b1;
               chk_pos_in = addr_ff;
               chk_vld_in = 1'b1;
            end
         end
         spg_pkg::ST_POST: begin
            if (post_load) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = res_prime_ff;
               rsp_exh_in = res_exh_ff;
            end
         end
         spg_pkg::ST_MARK: begin
            if (mark_go) begin
               ram_ctl.wr_en = 1'b1;
               ram_waddr = MAP_AW'(m_ff);
               ram_wdata = epoch_ff;
               m_in = m_ff + {1'b0, p_ff};
            end
         end
         default: begin
            busy_in = 1'b0;
         end
      endcase

      if (csr_wr_en) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spg_pkg::ST_CLEAR;
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         epoch_ff <= spg_pkg::EPOCH_FIRST;
         scan_ff <= spg_pkg::SCAN_START;
         chk_vld_ff <= 1'b0;
         clr_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         epoch_ff <= epoch_in;
         scan_ff <= scan_in;
         chk_vld_ff <= chk_vld_in;
         clr_addr_ff <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      chk_pos_ff <= chk_pos_in;
      p_ff <= p_in;
      m_ff <= m_in;
      res_prime_ff <= res_prime_in;
      res_exh_ff <= res_exh_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_exh_ff <= rsp_exh_in;
   end

`ifndef SYNTHESIS
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_ctl.wr_en && ram_ctl.rd_en))
      else $error("map read and write in the same cycle");

   a_epoch_live: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != spg_pkg::EPOCH_NONE)
      else $error("epoch tag equals the cleared tag");

   a_prime_min: assert property (@(posedge clock) disable iff (reset)
      (post_load && !res_exh_ff) |=> (rsp_prime_ff >= 16'd2))
      else $error("reported prime below two");

   a_exh_zero: assert property (@(posedge clock) disable iff (reset)
      (post_load && res_exh_ff) |=> (rsp_prime_ff == '0))
      else $error("exhausted response carries nonzero prime");

   a_mark_above: assert property (@(posedge clock) disable iff (reset)
      (state_ff == spg_pkg::ST_MARK) |-> (m_ff > {1'b0, p_ff}))
      else $error("marking at or below the prime");
`endif

endmodule

// ===== hw/rtl/sieve_prime_generator.sv =====
// A request scans the map entry by entry up to its response, then each multiple of the
// prime found is marked before the next request is taken.
// One request is in flight at a time; the map read port paces the scan, the write port the marking.
// A restart that follows 14 earlier restarts or limit writes adds a clear of the whole map.
// Reset: synchronous; the map is then cleared, and req_chan.ready stays low until the clear is done.
module sieve_prime_generator #(
   parameter int LIMIT_MAX = 65535
) (
   input  logic                       clock,
   input  logic                       reset,
   spg_req_if.sink                    req_chan,
   spg_rsp_if.source                  rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [spg_pkg::LIM_W-1:0]  csr_wr_data
);

   localparam int MAP_DEPTH = LIMIT_MAX + 1;
   localparam int MAP_AW = $clog2(MAP_DEPTH);

   logic [spg_pkg::LIM_W-1:0]    limit_ff;
   logic [spg_pkg::LIM_W-1:0]    lim;
   spg_pkg::spg_ram_ctl_type     ram_ctl;
   logic [MAP_AW-1:0]            ram_waddr;
   logic [MAP_AW-1:0]            ram_raddr;
   logic [spg_pkg::EPOCH_W-1:0]  ram_wdata;
   logic [spg_pkg::EPOCH_W-1:0]  ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= spg_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   assign lim = (32'(limit_ff) > 32'(LIMIT_MAX)) ? spg_pkg::LIM_W'(LIMIT_MAX) : limit_ff;

   spg_engine #(
      .LIMIT_MAX (LIMIT_MAX),
      .MAP_AW    (MAP_AW)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .lim       (lim),
      .ram_ctl   (ram_ctl),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   spg_map_ram #(
      .MAP_AW    (MAP_AW),
      .MAP_DEPTH (MAP_DEPTH)
   ) u_map (
      .clock (clock),
      .ctl   (ram_ctl),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

// ===== bench/sieve_prime_generator_tb.sv =====
// Self-checking bench for sieve_prime_generator: directed table, then random limit runs.
// Predicts each untyped response with a bit-level sieve kept in the bench; typed rows give their own.
// Depends on spg_pkg and the spg_req_if / spg_rsp_if channel interfaces.
module sieve_prime_generator_tb;

   localparam int RANDOM_ITEMS = 1800;
   localparam int WATCHDOG_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [spg_pkg::LIM_W-1:0] prime;
      logic                      exhausted;
   } prime_rsp_type;

   typedef enum logic {ROW_REQUEST, ROW_LIMIT} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic                      restart;
      logic [spg_pkg::LIM_W-1:0] value;
      logic                      typed;
      logic [spg_pkg::LIM_W-1:0] prime;
      logic                      exhausted;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [spg_pkg::LIM_W-1:0] csr_wr_data;

   spg_req_if req_bus();
   spg_rsp_if rsp_bus();

   sieve_prime_generator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // sieve predictor state
   bit composite_q [0:65535];
   int scan_q = spg_pkg::SCAN_START;
   int limit_q = spg_pkg::LIMIT_RESET;
   int mark_tail = 0;

   prime_rsp_type expected_q [$];
   int err_count = 0;
   int req_count = 0;
   int rsp_count = 0;
   int exhausted_count = 0;
   int restart_count = 0;
   int limit_writes = 0;
   int quiet_cycles = 0;
   bit steady = 1'b0;
   bit hold_request = 1'b0;

   stim_row_type dir_table [30] = '{
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd2,  1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd3,  1'b0},
      '{ROW_REQUEST, 1'b1, 16'd0,     1'b1, 16'd2,  1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd3,  1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd5,  1'b0},
      '{ROW_LIMIT,   1'b0, 16'd0,     1'b0, 16'd0,  1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd0,  1'b1},
      '{ROW_REQUEST, 1'b1, 16'd0,     1'b1, 16'd0,  1'b1},
      '{ROW_LIMIT,   1'b0, 16'd1,     1'b0, 16'd0,  1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd0,  1'b1},
      '{ROW_LIMIT,   1'b0, 16'd2,     1'b0, 16'd0,  1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd2,  1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd0,  1'b1},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd0,  1'b1},
      '{ROW_REQUEST, 1'b1, 16'd0,     1'b1, 16'd2,  1'b0},
      '{ROW_LIMIT,   1'b0, 16'd13,    1'b0, 16'd0,  1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd2,  1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd3,  1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd5,  1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd7,  1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd11, 1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd13, 1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd0,  1'b1},
      '{ROW_REQUEST, 1'b1, 16'd0,     1'b1, 16'd2,  1'b0},
      '{ROW_LIMIT,   1'b0, 16'd4,     1'b0, 16'd0,  1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b0, 16'd0,  1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b0, 16'd0,  1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b0, 16'd0,  1'b0},
      '{ROW_LIMIT,   1'b0, 16'd65535, 1'b0, 16'd0,  1'b0},
      '{ROW_REQUEST, 1'b0, 16'd0,     1'b1, 16'd2,  1'b0}
   };

   function automatic void clear_sieve();
      for (int n = 0; n <= limit_q; n++) begin
         composite_q[n] = 1'b0;
      end
      scan_q = spg_pkg::SCAN_START;
   endfunction

   function automatic prime_rsp_type next_prime(input logic restart);
      prime_rsp_type rsp;
      int p;
      int m;
      if (restart) begin
         clear_sieve();
      end
      p = (scan_q < 2) ? 2 : scan_q;
      while (p <= limit_q && composite_q[p]) begin
         p++;
      end
      mark_tail = 0;
      if (p > limit_q) begin
         scan_q = limit_q + 1;
         rsp.prime = '0;
         rsp.exhausted = 1'b1;
      end else begin
         for (m = p + p; m <= limit_q; m += p) begin
            composite_q[m] = 1'b1;
            mark_tail++;
         end
         scan_q = p + 1;
         rsp.prime = p[spg_pkg::LIM_W-1:0];
         rsp.exhausted = 1'b0;
      end
      return rsp;
   endfunction

   task automatic push_request(input logic restart, input logic typed,
                               input logic [spg_pkg::LIM_W-1:0] typed_prime,
                               input logic typed_exh);
      prime_rsp_type exp_rsp;
      if (!steady && $urandom_range(99) < 6) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.restart <= restart;
      do @(posedge clock); while (!req_bus.ready);
      exp_rsp = next_prime(restart);
      if (typed) begin
         exp_rsp.prime = typed_prime;
         exp_rsp.exhausted = typed_exh;
      end
      expected_q.push_back(exp_rsp);
      req_count++;
      if (restart) begin
         restart_count++;
      end
      @(negedge clock);
   endtask

   // drop valid, wait out every response, then let the marking pass finish
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (mark_tail + 16) @(negedge clock);
   endtask

   task automatic write_limit(input logic [spg_pkg::LIM_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      limit_q = value;
      clear_sieve();
      mark_tail = 0;
      limit_writes++;
   endtask

   initial begin : stimulus
      int seq;
      int n;
      int pick;
      int lim;
      int start_count;
      req_bus.valid = 1'b0;
      req_bus.restart = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_LIMIT) begin
            settle();
            write_limit(dir_table[i].value);
         end else begin
            push_request(dir_table[i].restart, dir_table[i].typed,
                         dir_table[i].prime, dir_table[i].exhausted);
         end
      end

      seq = 0;
      start_count = req_count;
      while (req_count - start_count < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (seq == 6) begin
            lim = $urandom_range(60000, 65535);
         end else if (pick < 5) begin
            lim = $urandom_range(0, 1);
         end else if (pick < 80) begin
            lim = $urandom_range(2, 300);
         end else begin
            lim = $urandom_range(301, 4000);
         end
         settle();
         write_limit(lim[spg_pkg::LIM_W-1:0]);
         steady = (seq == 4 || seq == 5);
         if (seq == 2) begin
            hold_request = 1'b1;
         end
         n = (seq == 6) ? 12 : $urandom_range(10, 90);
         repeat (n) begin
            push_request($urandom_range(99) < 3, 1'b0, '0, 1'b0);
         end
         seq++;
      end
      steady = 1'b0;
      settle();

      $display("covered %0d requests and %0d responses, %0d of them exhausted",
               req_count, rsp_count, exhausted_count);
      $display("%0d restarts, %0d limit writes from 0 up to 65535",
               restart_count, limit_writes);
      if (err_count == 0 && expected_q.size() == 0) begin
         $display("sieve_prime_generator_tb: done, clean");
      end else begin
         $display("sieve_prime_generator_tb: done, errors");
      end
      $finish;
   end

   initial begin : receiver
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= 6);
         end
      end
   end

   always @(posedge clock) begin
      prime_rsp_type exp_rsp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_count++;
         if (rsp_bus.exhausted) begin
            exhausted_count++;
         end
         if (expected_q.size() == 0) begin
            $error("unexpected transfer: prime %0d exhausted %0b",
                   rsp_bus.prime, rsp_bus.exhausted);
            err_count++;
         end else begin
            exp_rsp = expected_q.pop_front();
            if (rsp_bus.prime !== exp_rsp.prime) begin
               $error("prime: expected %0d, got %0d", exp_rsp.prime, rsp_bus.prime);
               err_count++;
            end
            if (rsp_bus.exhausted !== exp_rsp.exhausted) begin
               $error("exhausted: expected %0b, got %0b",
                      exp_rsp.exhausted, rsp_bus.exhausted);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_bus.valid && req_bus.ready)
          || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("sieve_prime_generator_tb: done, errors");
         $finish;
      end
   end

endmodule

// ===== sieve_prime_generator.f =====
hw/rtl/spg_pkg.sv
hw/rtl/spg_if.sv
hw/rtl/spg_map_ram.sv
hw/rtl/spg_engine.sv
hw/rtl/sieve_prime_generator.sv
bench/sieve_prime_generator_tb.sv
